// ----- src/mpf_pkg.sv -----
// ----------------------------------------------------------------------------
// mpf_pkg
// Shared types and constants of the monochrome page framebuffer.
// ----------------------------------------------------------------------------
`default_nettype none

package mpf_pkg;

  // default panel geometry
  localparam int unsigned COLUMNS_DEF = 128;
  localparam int unsigned PAGES_DEF   = 8;

  // depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // widest coordinates carried in a queued command
  localparam int unsigned XW = 8;
  localparam int unsigned YQ = 6;

  // refresh stream command bytes
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;

  // item kinds on the command port
  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_PULL  = 2'd3
  } kind_e;

  // operations carried out by the back end
  typedef enum logic [1:0] {
    OP_RECT,
    OP_CLEAR,
    OP_PULL
  } op_e;

  // back end states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_RECT_RD,
    BK_RECT_WR,
    BK_PULL_RD,
    BK_PULL_OUT
  } bk_state_e;

  // one queued command, rectangle already clipped and non-empty
  typedef struct packed {
    op_e             op;
    logic [XW-1:0]   x_lo;
    logic [XW-1:0]   x_hi;
    logic [YQ-1:0]   y_lo;
    logic [YQ-1:0]   y_hi;
    logic            on;
    logic [7:0]      fill;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/mpf_ram.sv -----
// ----------------------------------------------------------------------------
// mpf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mpf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/mpf_fifo.sv -----
// ----------------------------------------------------------------------------
// mpf_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mpf_fifo #(
  parameter int unsigned Depth = mpf_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire mpf_pkg::cmd_t wdata_i,
  input  wire logic          pop_i,
  output mpf_pkg::cmd_t      rdata_o,
  output logic               full_o,
  output logic               empty_o
);
  import mpf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/mpf_front.sv -----
// ----------------------------------------------------------------------------
// mpf_front
// Accepts items, clips and classifies them, and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mpf_front #(
  parameter int unsigned Columns = mpf_pkg::COLUMNS_DEF,
  parameter int unsigned Pages   = mpf_pkg::PAGES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    kind_i,
  input  wire logic [7:0]    x_first_i,
  input  wire logic [7:0]    y_first_i,
  input  wire logic [7:0]    x_second_i,
  input  wire logic [7:0]    y_second_i,
  input  wire logic [7:0]    value_i,
  input  wire logic          init_i,
  input  wire logic          pop_i,
  output mpf_pkg::cmd_t      head_o,
  output logic               empty_o
);
  import mpf_pkg::*;

  localparam logic [7:0] XMax = 8'(Columns - 1);
  localparam logic [7:0] YMax = 8'(Pages * 8 - 1);

  cmd_t       cmd;
  logic       keep;
  logic       full;
  logic       push;
  logic [7:0] x_hi_clip, y_hi_clip;

  assign x_hi_clip = (x_second_i > XMax) ? XMax : x_second_i;
  assign y_hi_clip = (y_second_i > YMax) ? YMax : y_second_i;

  // a point is a one-pixel rectangle; empty rectangles are dropped here
  always_comb begin
    cmd      = '0;
    cmd.on   = |value_i;
    cmd.fill = value_i;
    keep     = 1'b1;
    case (kind_i)
      KIND_POINT: begin
        cmd.op   = OP_RECT;
        cmd.x_lo = x_first_i;
        cmd.x_hi = x_first_i;
        cmd.y_lo = YQ'(y_first_i);
        cmd.y_hi = YQ'(y_first_i);
        keep     = (x_first_i <= XMax) && (y_first_i <= YMax);
      end
      KIND_FILL: begin
        cmd.op   = OP_RECT;
        cmd.x_lo = x_first_i;
        cmd.x_hi = x_hi_clip;
        cmd.y_lo = YQ'(y_first_i);
        cmd.y_hi = YQ'(y_hi_clip);
        keep     = (x_first_i <= x_hi_clip) && (y_first_i <= y_hi_clip);
      end
      KIND_CLEAR: begin
        cmd.op = OP_CLEAR;
      end
      default: begin
        cmd.op = OP_PULL;
      end
    endcase
  end

  assign busy = full || init_i;
  assign push = start && !busy && keep;

  mpf_fifo #(
    .Depth(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(cmd),
    .pop_i  (pop_i),
    .rdata_o(head_o),
    .full_o (full),
    .empty_o(empty_o)
  );

endmodule

`default_nettype wire

// ----- src/mpf_back.sv -----
// ----------------------------------------------------------------------------
// mpf_back
// Carries out queued commands on the pixel store and streams refresh bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module mpf_back #(
  parameter int unsigned Columns = mpf_pkg::COLUMNS_DEF,
  parameter int unsigned Pages   = mpf_pkg::PAGES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mpf_pkg::cmd_t head_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               init_o,
  output logic               strobe_o,
  output logic [7:0]         out_byte_o,
  output logic               is_data_o,
  output logic               frame_end_o
);
  import mpf_pkg::*;

  localparam int unsigned CW  = $clog2(Columns);
  localparam int unsigned PW  = (Pages > 1) ? $clog2(Pages) : 1;
  localparam int unsigned YW  = PW + 3;
  localparam int unsigned AW  = PW + CW;
  localparam int unsigned PSW = $clog2(Columns + 3);

  bk_state_e state_q, state_d;

  // store port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // clear sweep
  logic [CW-1:0] sw_col_q;
  logic [PW-1:0] sw_pg_q;
  logic [7:0]    clr_byte_q;
  logic          init_q;
  logic          sweep_last;

  // rectangle walk
  logic [CW-1:0] x_lo_q, x_hi_q, cur_x_q;
  logic [YW-1:0] y_lo_q, y_hi_q;
  logic [PW-1:0] cur_b_q;
  logic          on_q;
  logic [7:0]    mask;
  logic [AW-1:0] rect_addr;
  logic          rect_last;

  // refresh stream
  logic [PW-1:0]  ref_page_q;
  logic [PSW-1:0] ref_pos_q;
  logic           strobe_q;
  logic [7:0]     out_byte_q, pull_byte;
  logic           is_data_q, frame_end_q;
  logic           pull_data, pull_page_end, pull_frame_end;

  mpf_ram #(
    .Width(8),
    .Depth(2 ** AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign sweep_last = (sw_col_q == CW'(Columns - 1)) && (sw_pg_q == PW'(Pages - 1));
  assign rect_addr  = {PW'(Pages - 1) - cur_b_q, cur_x_q};
  assign rect_last  = (cur_x_q == x_hi_q) && (cur_b_q == y_hi_q[YW-1:3]);

  // rows of the current row block that fall inside the rectangle
  always_comb begin
    logic [YW-1:0] row;
    mask = '0;
    for (int r = 0; r < 8; r++) begin
      row = {cur_b_q, 3'(r)};
      mask[7-r] = (row >= y_lo_q) && (row <= y_hi_q);
    end
  end

  assign pull_data      = (ref_pos_q >= PSW'(3));
  assign pull_page_end  = (ref_pos_q == PSW'(Columns + 2));
  assign pull_frame_end = pull_page_end && (ref_page_q == PW'(Pages - 1));

  always_comb begin
    if (ref_pos_q == PSW'(0)) begin
      pull_byte = CMD_PAGE_BASE + 8'(ref_page_q);
    end else if (ref_pos_q == PSW'(1)) begin
      pull_byte = CMD_COL_LO;
    end else if (ref_pos_q == PSW'(2)) begin
      pull_byte = CMD_COL_HI;
    end else begin
      pull_byte = ram_rdata;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          case (head_i.op)
            OP_RECT:  state_d = BK_RECT_RD;
            OP_CLEAR: state_d = BK_CLEAR;
            default:  state_d = BK_PULL_RD;
          endcase
        end
      end
      BK_CLEAR:    if (sweep_last) state_d = BK_IDLE;
      BK_RECT_RD:  state_d = BK_RECT_WR;
      BK_RECT_WR:  state_d = rect_last ? BK_IDLE : BK_RECT_RD;
      BK_PULL_RD:  state_d = BK_PULL_OUT;
      BK_PULL_OUT: state_d = BK_IDLE;
      default:     state_d = BK_IDLE;
    endcase
  end

  // store and queue controls
  always_comb begin
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = rect_addr;
    ram_wdata = ram_rdata;
    ram_raddr = rect_addr;
    case (state_q)
      BK_IDLE: pop_o = !empty_i;
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = {sw_pg_q, sw_col_q};
        ram_wdata = clr_byte_q;
      end
      BK_RECT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = on_q ? (ram_rdata | mask) : (ram_rdata & ~mask);
      end
      BK_PULL_RD: ram_raddr = {ref_page_q, CW'(ref_pos_q - PSW'(3))};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_CLEAR;
      init_q     <= 1'b1;
      clr_byte_q <= '0;
      sw_col_q   <= '0;
      sw_pg_q    <= '0;
      ref_page_q <= '0;
      ref_pos_q  <= '0;
      strobe_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= 1'b0;
      case (state_q)
        BK_IDLE: begin
          if (!empty_i && head_i.op == OP_CLEAR) begin
            clr_byte_q <= head_i.fill;
          end
        end
        BK_CLEAR: begin
          if (sw_col_q == CW'(Columns - 1)) begin
            sw_col_q <= '0;
            if (sw_pg_q == PW'(Pages - 1)) begin
              sw_pg_q <= '0;
              init_q  <= 1'b0;
            end else begin
              sw_pg_q <= sw_pg_q + 1'b1;
            end
          end else begin
            sw_col_q <= sw_col_q + 1'b1;
          end
        end
        BK_PULL_OUT: begin
          strobe_q <= 1'b1;
          if (pull_page_end) begin
            ref_pos_q  <= '0;
            ref_page_q <= (ref_page_q == PW'(Pages - 1)) ? '0 : ref_page_q + 1'b1;
          end else begin
            ref_pos_q <= ref_pos_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        x_lo_q  <= CW'(head_i.x_lo);
        x_hi_q  <= CW'(head_i.x_hi);
        y_lo_q  <= YW'(head_i.y_lo);
        y_hi_q  <= YW'(head_i.y_hi);
        on_q    <= head_i.on;
        cur_x_q <= CW'(head_i.x_lo);
        cur_b_q <= PW'(head_i.y_lo[YQ-1:3]);
      end
      BK_RECT_WR: begin
        if (cur_x_q == x_hi_q) begin
          cur_x_q <= x_lo_q;
          cur_b_q <= cur_b_q + 1'b1;
        end else begin
          cur_x_q <= cur_x_q + 1'b1;
        end
      end
      BK_PULL_OUT: begin
        out_byte_q  <= pull_byte;
        is_data_q   <= pull_data;
        frame_end_q <= pull_frame_end;
      end
      default: ;
    endcase
  end

  assign init_o      = init_q;
  assign strobe_o    = strobe_q;
  assign out_byte_o  = out_byte_q;
  assign is_data_o   = is_data_q;
  assign frame_end_o = frame_end_q;

endmodule

`default_nettype wire

// ----- src/mono_page_framebuffer.sv -----
// ----------------------------------------------------------------------------
// mono_page_framebuffer
// One-bit page framebuffer with point, rectangle fill, clear and refresh pull.
// ----------------------------------------------------------------------------
// usage:
//   command channel: an item transfers on a rising edge with start high and
//   busy low; kind_i selects point, fill, clear or pull, the other fields
//   carry coordinates and the pixel or clear value
//   result channel: only a pull returns a byte; it sits on out_byte_o,
//   is_data_o and frame_end_o for one cycle with strobe_o high and transfers
//   at the end of that cycle; the receiver cannot stall, so results never wait
//   front end clips and queues items (queue of QUEUE_DEPTH commands), back end
//   works them off the store; busy is high while the queue is full or the
//   reset sweep runs
//   a pull's byte goes through the queue, the idle state, a store read and
//   the output state, and shows registered with strobe_o
//   service: the back end takes each command off the queue in its idle state,
//   then a pull takes a store read and an output, a point a store read and a
//   write back, a fill a read and write back per column and row block
//   covered, a clear one store write per cycle over all COLUMNS*PAGES bytes
//   reset: the store is swept to zero, all COLUMNS*PAGES bytes (1024 by
//   default), with busy high; the refresh stream restarts at page 0
// ----------------------------------------------------------------------------
`default_nettype none

module mono_page_framebuffer #(
  parameter int unsigned COLUMNS = mpf_pkg::COLUMNS_DEF,
  parameter int unsigned PAGES   = mpf_pkg::PAGES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // command channel
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] x_first_i,
  input  wire logic [7:0] y_first_i,
  input  wire logic [7:0] x_second_i,
  input  wire logic [7:0] y_second_i,
  input  wire logic [7:0] value_i,
  // result channel
  output logic            strobe_o,
  output logic [7:0]      out_byte_o,
  output logic            is_data_o,
  output logic            frame_end_o
);
  import mpf_pkg::*;

  cmd_t head;
  logic empty;
  logic pop;
  logic init;

  // front: transfer, clip, classify, queue
  mpf_front #(
    .Columns(COLUMNS),
    .Pages  (PAGES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .kind_i    (kind_i),
    .x_first_i (x_first_i),
    .y_first_i (y_first_i),
    .x_second_i(x_second_i),
    .y_second_i(y_second_i),
    .value_i   (value_i),
    .init_i    (init),
    .pop_i     (pop),
    .head_o    (head),
    .empty_o   (empty)
  );

  // back: store sweeps, read-modify-write, refresh stream
  mpf_back #(
    .Columns(COLUMNS),
    .Pages  (PAGES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .init_o     (init),
    .strobe_o   (strobe_o),
    .out_byte_o (out_byte_o),
    .is_data_o  (is_data_o),
    .frame_end_o(frame_end_o)
  );

`ifndef SYNTHESIS
  // no transfer taken while the reset sweep runs
  a_init_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) init |-> busy)
    else $error("command taken during reset sweep");

  // no refresh byte can come out of the store before it is cleared
  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni) init |-> !strobe_o)
    else $error("result during reset sweep");

  // every pull passes the idle and store read states before its output state, so strobes never touch
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni) strobe_o |=> !strobe_o)
    else $error("back-to-back result strobes");

  // the frame ends on a data byte
  a_end_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && frame_end_o) |-> is_data_o)
    else $error("frame end on a command byte");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the one-bit page framebuffer. A queue of points,
// rectangle fills, clears and refresh pulls is driven in random bursts; a
// shadow copy of the panel and of the refresh scan predicts every stream
// byte, which is checked against the strobed result port.
// ----------------------------------------------------------------------------

module tb_top;

  import mpf_pkg::*;

  localparam int NCOL     = COLUMNS_DEF;
  localparam int NPAGE    = PAGES_DEF;
  localparam int NROW     = NPAGE * 8;
  localparam int PAGE_LEN = NCOL + 3;      // three command bytes, then column data
  localparam int TAIL     = 7000;          // queued fills and clears still draining
  localparam int N_RANDOM = 1350;

  // one command transfer as the host issues it
  typedef struct {
    kind_e      kind;
    logic [7:0] x1;
    logic [7:0] y1;
    logic [7:0] x2;
    logic [7:0] y2;
    logic [7:0] val;
    bit         hold;                      // wait until every pull has answered
  } panel_cmd_t;

  // one byte of the refresh stream
  typedef struct {
    logic [7:0] octet;
    logic       data;
    logic       fend;
  } stream_byte_t;

  logic clk_i;
  logic rst_ni;

  logic       start;
  logic       busy;
  kind_e      kind_q;
  logic [7:0] x_first_q;
  logic [7:0] y_first_q;
  logic [7:0] x_second_q;
  logic [7:0] y_second_q;
  logic [7:0] value_q;
  logic       strobe_o;
  logic [7:0] out_byte_o;
  logic       is_data_o;
  logic       frame_end_o;

  // host side: commands not yet sent, the one on the bus
  panel_cmd_t   cmd_backlog[$];
  panel_cmd_t   on_bus;
  bit           took;
  int           burst_left;
  int           gap_left;

  // shadow panel and scan pointer
  logic [7:0]   panel_img[NCOL*NPAGE];
  int           scan_page;
  int           scan_pos;
  stream_byte_t stream_due[$];

  int           fail_count;
  longint       cycle_count;
  longint       cycle_cap;
  longint       run_budget;

  mono_page_framebuffer #(
    .COLUMNS(NCOL),
    .PAGES  (NPAGE)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .kind_i     (kind_q),
    .x_first_i  (x_first_q),
    .y_first_i  (y_first_q),
    .x_second_i (x_second_q),
    .y_second_i (y_second_q),
    .value_i    (value_q),
    .strobe_o   (strobe_o),
    .out_byte_o (out_byte_o),
    .is_data_o  (is_data_o),
    .frame_end_o(frame_end_o)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    fail_count++;
  endtask

  // set or clear one pixel; off-panel points are dropped
  function automatic void plot_pixel(input int x, input int y, input bit on);
    int idx;
    logic [7:0] mask;
    if (x > NCOL - 1 || y > NROW - 1) return;
    // reversed page order, row 0 at the top bit of the last page
    idx  = x * NPAGE + (NPAGE - 1 - y / 8);
    mask = 8'h80 >> (y % 8);
    if (on) panel_img[idx] = panel_img[idx] | mask;
    else    panel_img[idx] = panel_img[idx] & ~mask;
  endfunction

  // apply one transferred command to the shadow panel; a pull yields a byte
  task automatic render_item(input panel_cmd_t it);
    int xb;
    int yb;
    int pg;
    int ps;
    stream_byte_t r;
    case (it.kind)
      KIND_POINT: begin
        plot_pixel(it.x1, it.y1, it.val != 8'd0);
      end
      KIND_FILL: begin
        // right and bottom edges clip; a first edge past them draws nothing
        xb = (it.x2 > NCOL - 1) ? NCOL - 1 : it.x2;
        yb = (it.y2 > NROW - 1) ? NROW - 1 : it.y2;
        for (int x = it.x1; x <= xb; x++) begin
          for (int y = it.y1; y <= yb; y++) begin
            plot_pixel(x, y, it.val != 8'd0);
          end
        end
      end
      KIND_CLEAR: begin
        foreach (panel_img[i]) panel_img[i] = it.val;
      end
      default: begin
        pg     = scan_page;
        ps     = scan_pos;
        r.data = 1'b0;
        r.fend = 1'b0;
        if (ps == 0)      r.octet = CMD_PAGE_BASE + 8'(pg);
        else if (ps == 1) r.octet = CMD_COL_LO;
        else if (ps == 2) r.octet = CMD_COL_HI;
        else begin
          r.octet = panel_img[(ps - 3) * NPAGE + pg];
          r.data  = 1'b1;
        end
        ps++;
        // end of page; after the last page the frame wraps to page 0
        if (ps >= PAGE_LEN) begin
          ps = 0;
          if (pg == NPAGE - 1) begin
            r.fend = 1'b1;
            pg     = 0;
          end else begin
            pg++;
          end
        end
        scan_page = pg;
        scan_pos  = ps;
        stream_due.push_back(r);
      end
    endcase
  endtask

  // queue a command and add its worst-case service time to the run budget
  task automatic queue_item(input kind_e k, input int x1, input int y1, input int x2,
                            input int y2, input int val, input bit hold);
    panel_cmd_t it;
    int cols;
    it.kind = k;
    it.x1   = 8'(x1);
    it.y1   = 8'(y1);
    it.x2   = 8'(x2);
    it.y2   = 8'(y2);
    it.val  = 8'(val);
    it.hold = hold;
    cmd_backlog.push_back(it);
    case (k)
      KIND_CLEAR: run_budget += NCOL * NPAGE + 16;
      KIND_FILL: begin
        cols = ((x2 > NCOL - 1) ? NCOL - 1 : x2) - x1 + 1;
        if (cols < 0) cols = 0;
        run_budget += 2 * cols * NPAGE + 16;
      end
      default: run_budget += 16;
    endcase
    run_budget += 32;                      // longest gap between bursts
  endtask

  // driver: one command on the bus at a time, changes at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // transfer still pending, hold the bus
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (cmd_backlog.size() == 0 ||
                 (cmd_backlog[0].hold && stream_due.size() != 0)) begin
      start <= 1'b0;
    end else begin
      on_bus      = cmd_backlog.pop_front();
      kind_q     <= on_bus.kind;
      x_first_q  <= on_bus.x1;
      y_first_q  <= on_bus.y1;
      x_second_q <= on_bus.x2;
      y_second_q <= on_bus.y2;
      value_q    <= on_bus.val;
      start      <= 1'b1;
      if (burst_left <= 1) begin
        // mostly short bursts, now and then a long stretch with no idling
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 30);
        gap_left   = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  end

  // monitor: checks the strobed byte, then books the command that transferred
  always @(posedge clk_i) begin
    stream_byte_t want;
    cycle_count++;
    if (cycle_count > cycle_cap) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      took = rst_ni && start && !busy;
      if (rst_ni && strobe_o) begin
        if (stream_due.size() == 0) begin
          report_mismatch("unexpected stream byte", out_byte_o, 8'h00);
        end else begin
          want = stream_due.pop_front();
          if (out_byte_o !== want.octet)
            report_mismatch("out_byte", out_byte_o, want.octet);
          if (is_data_o !== want.data)
            report_mismatch("is_data", 8'(is_data_o), 8'(want.data));
          if (frame_end_o !== want.fend)
            report_mismatch("frame_end", 8'(frame_end_o), 8'(want.fend));
        end
      end
      if (took) render_item(on_bus);
    end
  end

  initial begin
    int r;
    int x1;
    int y1;
    int x2;
    int y2;
    int val;

    rst_ni      = 1'b0;
    start       = 1'b0;
    kind_q      = KIND_POINT;
    x_first_q   = 8'd0;
    y_first_q   = 8'd0;
    x_second_q  = 8'd0;
    y_second_q  = 8'd0;
    value_q     = 8'd0;
    took        = 1'b0;
    burst_left  = $urandom_range(1, 30);
    gap_left    = 0;
    scan_page   = 0;
    scan_pos    = 0;
    fail_count  = 0;
    cycle_count = 0;
    run_budget  = 0;
    foreach (panel_img[i]) panel_img[i] = 8'h00;

    // directed: first page commands, ignored fields at both extremes
    queue_item(KIND_PULL,    0,   0,   0,   0,   0, 1'b0);
    queue_item(KIND_PULL,  255, 255, 255, 255, 255, 1'b0);
    queue_item(KIND_PULL,  170,  85, 170,  85, 170, 1'b0);
    // corner pixels, then one switched back off
    queue_item(KIND_POINT,   0,   0, 255, 255,   1, 1'b0);
    queue_item(KIND_POINT, 127,  63,   0,   0, 255, 1'b0);
    queue_item(KIND_POINT, 127,  63, 255, 255,   0, 1'b0);
    // points off the panel
    queue_item(KIND_POINT, 128,  10,   0,   0,   1, 1'b0);
    queue_item(KIND_POINT,  10,  64,   0,   0,   1, 1'b0);
    queue_item(KIND_POINT, 255, 255,   0,   0,   1, 1'b0);
    // fill clipped on both edges, fills that draw nothing on one axis
    queue_item(KIND_FILL,    5,   3, 255, 255, 128, 1'b0);
    queue_item(KIND_FILL,  200,   0, 250,  20,   1, 1'b0);
    queue_item(KIND_FILL,    0,  70,  20,  80,   1, 1'b0);
    queue_item(KIND_FILL,   10,   0,   5,  63,   1, 1'b0);
    queue_item(KIND_FILL,    7,   7,   7,   7,   1, 1'b0);
    queue_item(KIND_FILL,    0,   0, 127,  63,   0, 1'b0);
    // clears with both byte extremes and a pattern
    queue_item(KIND_CLEAR,   0,   0,   0,   0, 165, 1'b0);
    queue_item(KIND_PULL,    0,   0,   0,   0,   0, 1'b0);
    queue_item(KIND_PULL,    0,   0,   0,   0,   0, 1'b0);
    queue_item(KIND_CLEAR,  99,  99,  99,  99, 255, 1'b0);
    queue_item(KIND_CLEAR,   0,   0,   0,   0,   0, 1'b0);
    queue_item(KIND_POINT,   3,   5,   0,   0,  64, 1'b0);
    // sender pauses until every pull has answered
    queue_item(KIND_PULL,    0,   0,   0,   0,   0, 1'b1);
    queue_item(KIND_PULL,    0,   0,   0,   0,   0, 1'b0);

    // random: pull heavy so the stream wraps, draws spread over the panel
    for (int n = 0; n < N_RANDOM; n++) begin
      r   = $urandom_range(0, 99);
      val = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 255);
      if (r < 78) begin
        queue_item(KIND_PULL, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 99) == 0);
      end else if (r < 90) begin
        x1 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 127);
        y1 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 63);
        queue_item(KIND_POINT, x1, y1, $urandom_range(0, 255), $urandom_range(0, 255),
                   val, 1'b0);
      end else if (r < 98) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          // wide fill, the slow case
          x1 = $urandom_range(0, 10);
          x2 = $urandom_range(100, 255);
          y1 = $urandom_range(0, 8);
          y2 = $urandom_range(50, 255);
        end else if (r == 1) begin
          x1 = $urandom_range(0, 255);
          x2 = $urandom_range(0, 255);
          y1 = $urandom_range(0, 255);
          y2 = $urandom_range(0, 255);
        end else begin
          x1 = $urandom_range(0, 140);
          x2 = x1 + $urandom_range(0, 12);
          y1 = $urandom_range(0, 70);
          y2 = y1 + $urandom_range(0, 12);
        end
        queue_item(KIND_FILL, x1, y1, x2, y2, val, 1'b0);
      end else begin
        queue_item(KIND_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), 1'b0);
      end
    end

    // generous cap: reset sweep, every command at its worst, the tail, all four times
    cycle_cap = 4 * (run_budget + NCOL * NPAGE + 64 + TAIL);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_backlog.size() != 0 || start || stream_due.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
